// ===== rtl/sha2_pkg.sv =====
// Shared types, constants and round functions for the SHA-224/256 hash core.
`timescale 1ns / 1ps
package sha2_pkg;

	localparam int unsigned WordW         = 32;
	localparam int unsigned IdxW          = 3;
	localparam int unsigned HashWords     = 8;
	localparam int unsigned BlockWords    = 16;
	localparam int unsigned NumRounds     = 64;
	localparam int unsigned MTdataW       = 40;
	localparam int unsigned PaddrW        = 3;
	localparam int unsigned QueueDepthDef = 4;

	typedef logic [WordW-1:0] word_t;

	// register index as seen on paddr[2]
	localparam logic RegVariant = 1'b0;

	localparam logic VarSha256 = 1'b0;
	localparam logic VarSha224 = 1'b1;

	localparam logic [IdxW-1:0] LastIdx256 = 3'd7;
	localparam logic [IdxW-1:0] LastIdx224 = 3'd6;

	typedef struct packed {
		logic  first_word;
		logic  final_word;
		word_t message_word;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} back_state_t;

	localparam word_t RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t Iv256 [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t Iv224 [HashWords] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	function automatic word_t ch_fn(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t maj_fn(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== rtl/sha2_front.sv =====
// Input side: accepts message words into a short queue ahead of the engine.
`timescale 1ns / 1ps
module sha2_front
	import sha2_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,   // message_word
	input  logic [0:0]    s_axis_tuser,   // first_word
	input  logic          s_axis_tlast,   // final_word
	input  logic          pop,
	output q_head_t       head
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	item_t             q_mem [DEPTH];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [CntW-1:0]   cnt_q;
	logic              push;
	logic              do_pop;

	assign s_axis_tready = (cnt_q != CntW'(DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign do_pop        = pop && head.valid;

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= '{first_word: s_axis_tuser[0], final_word: s_axis_tlast,
				message_word: s_axis_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sha2_back.sv =====
// Engine: collects blocks, runs the 64 compression rounds and emits the digest.
`timescale 1ns / 1ps
module sha2_back
	import sha2_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                variant,
	input  q_head_t             head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [MTdataW-1:0]  m_axis_tdata,   // digest_word, word_index, zero pad
	output logic                m_axis_tlast    // last_of_digest
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [3:0]        wib_q;
	logic [5:0]        round_q;
	logic              fin_pend_q;
	logic [IdxW-1:0]   idx_q;
	word_t             hash_q [HashWords];
	word_t             var_q  [HashWords];
	word_t             win_q  [BlockWords];
	logic              out_valid_q;
	word_t             out_data_q;
	logic [IdxW-1:0]   out_idx_q;
	logic              out_last_q;

	word_t             hash_cur [HashWords];
	logic [3:0]        wib_base;
	logic              blk_done;
	logic              load_out;
	logic              out_free;
	logic [IdxW-1:0]   last_idx;
	word_t             t1;
	word_t             t2;
	word_t             sched_new;

	always_comb begin
		for (int i = 0; i < HashWords; i++) begin
			if (head.item.first_word) begin
				hash_cur[i] = (variant == VarSha224) ? Iv224[i] : Iv256[i];
			end else begin
				hash_cur[i] = hash_q[i];
			end
		end
	end

	assign wib_base  = head.item.first_word ? '0 : wib_q;
	assign blk_done  = (wib_base == 4'(BlockWords - 1));
	assign last_idx  = (variant == VarSha224) ? LastIdx224 : LastIdx256;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign t1 = var_q[7] + big_sig1(var_q[4]) + ch_fn(var_q[4], var_q[5], var_q[6])
		+ RoundK[round_q] + win_q[0];
	assign t2 = big_sig0(var_q[0]) + maj_fn(var_q[0], var_q[1], var_q[2]);
	assign sched_new = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

	// outputs of the sequencer
	always_comb begin
		pop      = (state_q == ST_IDLE) && head.valid;
		load_out = (state_q == ST_EMIT) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					if (blk_done) begin
						state_d = ST_ROUND;
					end else if (head.item.final_word) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_ROUND: begin
				if (round_q == 6'(NumRounds - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = fin_pend_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (load_out && idx_q == last_idx) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// payload: message window, hash state, output data
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= head.item.message_word;
			if (head.item.first_word) begin
				hash_q <= hash_cur;
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= sched_new;
		end
		if (state_q == ST_ADD) begin
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= hash_q[i] + var_q[i];
			end
		end
		if (load_out) begin
			out_data_q <= hash_q[idx_q];
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == last_idx);
		end
	end

	// control and working variables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wib_q       <= '0;
			round_q     <= '0;
			fin_pend_q  <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HashWords; i++) begin
				var_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				wib_q <= head.item.final_word ? '0 : wib_base + 4'd1;
				idx_q <= '0;
				if (blk_done) begin
					var_q      <= hash_cur;
					round_q    <= '0;
					fin_pend_q <= head.item.final_word;
				end
			end
			if (state_q == ST_ROUND) begin
				var_q[7] <= var_q[6];
				var_q[6] <= var_q[5];
				var_q[5] <= var_q[4];
				var_q[4] <= var_q[3] + t1;
				var_q[3] <= var_q[2];
				var_q[2] <= var_q[1];
				var_q[1] <= var_q[0];
				var_q[0] <= t1 + t2;
				round_q  <= round_q + 6'd1;
			end
			if (state_q == ST_ADD) begin
				idx_q <= '0;
			end
			if (load_out) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(MTdataW - WordW - IdxW){1'b0}}, out_idx_q, out_data_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/sha224_256_hash_core.sv =====
// Top level of the SHA-224/256 hash core: stream ports, queue, engine, register port.
//
// Feed the padded message one big-endian 32-bit word per item on the slave stream;
// tuser marks the first word of a message (reloads the initial hash values chosen
// by the variant register) and tlast marks the final word, after which the digest
// comes out on the master stream, most significant word first: eight words for
// SHA-256, seven for SHA-224, with tlast on the final one. A four-entry queue in
// front of the engine takes words while the engine compresses or while a digest
// word waits on the output. The engine consumes one word per cycle while it is
// idle and takes none while it compresses or emits; every sixteenth word starts
// 64 rounds on the single round unit, after which the ADD state folds the result
// into the hash state. The digest follows once the last block is folded in. A
// final word that does not close a block drops the partial block and returns the
// hash state as it stands; a first word in mid-block drops the partial block.
// Write the variant register only while the core is idle.
`timescale 1ns / 1ps
module sha224_256_hash_core
	import sha2_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream: message words
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,   // [31:0] message_word
	input  logic [0:0]          s_axis_tuser,   // [0] first_word
	input  logic                s_axis_tlast,   // final_word
	// master stream: digest words
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [MTdataW-1:0]  m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic                m_axis_tlast,   // last_of_digest
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PaddrW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic     variant_q;
	logic     reg_wr;
	logic     pop;
	q_head_t  head;

	// register port: zero wait states, register index on paddr[2]
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == RegVariant) ? {31'd0, variant_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VarSha256;
		end else if (reg_wr && paddr[2] == RegVariant) begin
			variant_q <= pwdata[0];
		end
	end

	// queue the incoming words
	sha2_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.pop          (pop),
		.head         (head)
	);

	// compress blocks and drive the digest
	sha2_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.variant      (variant_q),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// ===== rtl/sha2_chk.sv =====
// Port-level checks on the digest stream of the hash core, bound to the top level.
`timescale 1ns / 1ps
module sha2_chk
	import sha2_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [MTdataW-1:0]  m_axis_tdata,
	input  logic                m_axis_tlast
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("digest item dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("digest item changed while stalled");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			m_axis_tdata[34:32] == LastIdx224 || m_axis_tdata[34:32] == LastIdx256)
		else $error("tlast on a word other than the sixth or seventh index");

	a_index7_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34:32] == LastIdx256 |-> m_axis_tlast)
		else $error("word index 7 without tlast");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[MTdataW-1:35] == '0)
		else $error("pad bits of digest item not zero");

endmodule

bind sha224_256_hash_core sha2_chk u_sha2_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
